>>> design/two_link_inverse_kinematics_defines.svh
// Assertion macros for the two-link arm solver.
// Expects clk and arst_n in the scope of use.
`ifndef TWO_LINK_INVERSE_KINEMATICS_DEFINES_SVH
`define TWO_LINK_INVERSE_KINEMATICS_DEFINES_SVH
`ifndef SYNTHESIS
`define TLIK_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tlik assertion failed");
`define TLIK_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tlik sequence assertion failed");
`else
`define TLIK_ASSERT(lbl, prop)
`define TLIK_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> design/tlik_pkg.sv
// Shared constants, codes and helpers for the two-link arm solver.
// No dependencies.
package tlik_pkg;

	localparam int CORDIC_STEPS = 20;
	localparam int DIV_STEPS    = 30;
	localparam int SQRT_STEPS   = 31;
	localparam int ATAN_W       = 56;
	localparam int ATAN_LAT     = CORDIC_STEPS + 4;
	localparam int SIDE_LEN     = DIV_STEPS + 3 + SQRT_STEPS;

	localparam logic [31:0] THRESH_BA    = 32'd68356528;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

	typedef enum logic [1:0] {
		REG_LINK1 = 2'd0,
		REG_LINK2 = 2'd1
	} reg_idx_t;

	localparam logic ST_OK       = 1'b0;
	localparam logic ST_UNREACH  = 1'b1;
	localparam logic SOL_PRIMARY = 1'b0;
	localparam logic SOL_ALT     = 1'b1;

	function automatic logic [31:0] atan_entry(input logic [4:0] k);
		logic [31:0] t;
		begin
			case (k)
				5'd0:  t = 32'h20000000;
				5'd1:  t = 32'h12E4051E;
				5'd2:  t = 32'h09FB385B;
				5'd3:  t = 32'h051111D4;
				5'd4:  t = 32'h028B0D43;
				5'd5:  t = 32'h0145D7E1;
				5'd6:  t = 32'h00A2F61E;
				5'd7:  t = 32'h00517C55;
				5'd8:  t = 32'h0028BE53;
				5'd9:  t = 32'h00145F2F;
				5'd10: t = 32'h000A2F98;
				5'd11: t = 32'h000517CC;
				5'd12: t = 32'h00028BE6;
				5'd13: t = 32'h000145F3;
				5'd14: t = 32'h0000A2FA;
				5'd15: t = 32'h0000517D;
				5'd16: t = 32'h000028BE;
				5'd17: t = 32'h0000145F;
				5'd18: t = 32'h00000A30;
				5'd19: t = 32'h00000518;
				5'd20: t = 32'h0000028C;
				5'd21: t = 32'h00000146;
				5'd22: t = 32'h000000A3;
				5'd23: t = 32'h00000051;
				5'd24: t = 32'h00000029;
				5'd25: t = 32'h00000014;
				5'd26: t = 32'h0000000A;
				5'd27: t = 32'h00000005;
				5'd28: t = 32'h00000003;
				5'd29: t = 32'h00000001;
				5'd30: t = 32'h00000001;
				default: t = 32'h00000000;
			endcase
			return t;
		end
	endfunction

	// arithmetic shift rounding toward zero
	function automatic logic signed [33:0] shr_tz(input logic signed [33:0] v,
			input logic [4:0] k);
		logic signed [33:0] m;
		begin
			m = -v;
			return v[33] ? -(m >>> k) : (v >>> k);
		end
	endfunction

endpackage

>>> design/tlik_div.sv
// Restoring divider, one quotient bit per pipeline stage.
// Depends on tlik_pkg.
module tlik_div import tlik_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [44:0] in_rem,
	input  logic [44:0] in_den,
	output logic        out_valid,
	output logic [29:0] out_quot
);

	typedef struct packed {
		logic        v;
		logic [44:0] rem;
		logic [44:0] den;
		logic [29:0] quot;
	} dstage_t;

	dstage_t din;
	dstage_t st [DIV_STEPS];

	assign din = '{v: in_valid, rem: in_rem, den: in_den, quot: '0};

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		dstage_t     prv;
		logic [45:0] r2;
		logic        ge;
		logic [45:0] rn;
		if (k == 0) begin : g_first
			assign prv = din;
		end else begin : g_next
			assign prv = st[k-1];
		end
		assign r2 = {prv.rem, 1'b0};
		assign ge = r2 >= {1'b0, prv.den};
		assign rn = ge ? (r2 - {1'b0, prv.den}) : r2;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st[k].v <= 1'b0;
			end else begin
				st[k].v    <= prv.v;
				st[k].rem  <= rn[44:0];
				st[k].den  <= prv.den;
				st[k].quot <= {prv.quot[28:0], ge};
			end
		end
	end

	assign out_valid = st[DIV_STEPS-1].v;
	assign out_quot  = st[DIV_STEPS-1].quot;

endmodule

>>> design/tlik_sqrt.sv
// Integer square root, one result bit per pipeline stage.
// Depends on tlik_pkg.
module tlik_sqrt import tlik_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [60:0] in_rad,
	output logic        out_valid,
	output logic [30:0] out_root
);

	typedef struct packed {
		logic        v;
		logic [61:0] rem;
		logic [61:0] root;
	} sstage_t;

	sstage_t din;
	sstage_t st [SQRT_STEPS];

	assign din = '{v: in_valid, rem: {1'b0, in_rad}, root: '0};

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [61:0] BIT = 62'(1) << (60 - 2 * k);
		sstage_t     prv;
		logic [61:0] t;
		logic        ge;
		if (k == 0) begin : g_first
			assign prv = din;
		end else begin : g_next
			assign prv = st[k-1];
		end
		assign t  = prv.root + BIT;
		assign ge = prv.rem >= t;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st[k].v <= 1'b0;
			end else begin
				st[k].v    <= prv.v;
				st[k].rem  <= ge ? (prv.rem - t) : prv.rem;
				st[k].root <= ge ? ((prv.root >> 1) + BIT) : (prv.root >> 1);
			end
		end
	end

	assign out_valid = st[SQRT_STEPS-1].v;
	assign out_root  = st[SQRT_STEPS-1].root[30:0];

endmodule

>>> design/tlik_atan2.sv
// Pipelined atan2 on wide signed operands: normalise, CORDIC vectoring, quadrant map.
// Depends on tlik_pkg; result is a 32-bit binary angle.
module tlik_atan2 import tlik_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic signed [ATAN_W-1:0] in_y,
	input  logic signed [ATAN_W-1:0] in_x,
	output logic                     out_valid,
	output logic [31:0]              out_angle
);

	typedef struct packed {
		logic              v;
		logic              xneg;
		logic              yneg;
		logic              axz;
		logic              ayz;
		logic signed [33:0] cx;
		logic signed [33:0] cy;
		logic [31:0]       z;
	} cstage_t;

	function automatic logic [5:0] msb_pos(input logic [ATAN_W-1:0] w);
		logic [5:0] p;
		begin
			p = '0;
			for (int i = 0; i < ATAN_W; i++) begin
				if (w[i]) p = 6'(i);
			end
			return p;
		end
	endfunction

	logic              v_s1, xneg_s1, yneg_s1;
	logic [ATAN_W-1:0] ax_s1, ay_s1;
	logic              v_s2, xneg_s2, yneg_s2, axz_s2, ayz_s2;
	logic [5:0]        pos_s2;
	logic [ATAN_W-1:0] ax_s2, ay_s2;
	logic [ATAN_W-1:0] nx, ny;
	logic              up;
	cstage_t           st [CORDIC_STEPS+1];
	logic              v_q;
	logic [31:0]       ang_q;
	logic [31:0]       th;
	cstage_t           fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1    <= in_valid;
			xneg_s1 <= in_x[ATAN_W-1];
			yneg_s1 <= in_y[ATAN_W-1];
			ax_s1   <= in_x[ATAN_W-1] ? -in_x : in_x;
			ay_s1   <= in_y[ATAN_W-1] ? -in_y : in_y;
			v_s2    <= v_s1;
			xneg_s2 <= xneg_s1;
			yneg_s2 <= yneg_s1;
			axz_s2  <= ax_s1 == '0;
			ayz_s2  <= ay_s1 == '0;
			pos_s2  <= msb_pos(ax_s1 | ay_s1);
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
		end
	end

	// bring the larger magnitude into [2^29, 2^30)
	assign up = pos_s2 < 6'd29;
	assign nx = up ? (ax_s2 << (6'd29 - pos_s2)) : (ax_s2 >> (pos_s2 - 6'd29));
	assign ny = up ? (ay_s2 << (6'd29 - pos_s2)) : (ay_s2 >> (pos_s2 - 6'd29));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st[0].v <= 1'b0;
		end else begin
			st[0].v    <= v_s2;
			st[0].xneg <= xneg_s2;
			st[0].yneg <= yneg_s2;
			st[0].axz  <= axz_s2;
			st[0].ayz  <= ayz_s2;
			st[0].cx   <= $signed({4'b0, nx[29:0]});
			st[0].cy   <= $signed({4'b0, ny[29:0]});
			st[0].z    <= '0;
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
		logic signed [33:0] dx, dy;
		logic               pos;
		assign dx  = shr_tz(st[k].cy, 5'(k));
		assign dy  = shr_tz(st[k].cx, 5'(k));
		assign pos = !st[k].cy[33];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st[k+1].v <= 1'b0;
			end else begin
				st[k+1].v    <= st[k].v;
				st[k+1].xneg <= st[k].xneg;
				st[k+1].yneg <= st[k].yneg;
				st[k+1].axz  <= st[k].axz;
				st[k+1].ayz  <= st[k].ayz;
				st[k+1].cx   <= pos ? (st[k].cx + dx) : (st[k].cx - dx);
				st[k+1].cy   <= pos ? (st[k].cy - dy) : (st[k].cy + dy);
				st[k+1].z    <= pos ? (st[k].z + atan_entry(5'(k)))
				                    : (st[k].z - atan_entry(5'(k)));
			end
		end
	end

	assign fin = st[CORDIC_STEPS];
	assign th  = fin.ayz ? 32'd0 : (fin.axz ? QUARTER_TURN : fin.z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= fin.v;
			if (!fin.xneg) ang_q <= fin.yneg ? (32'd0 - th) : th;
			else           ang_q <= fin.yneg ? (HALF_TURN + th) : (HALF_TURN - th);
		end
	end

	assign out_valid = v_q;
	assign out_angle = ang_q;

endmodule

>>> design/two_link_inverse_kinematics.sv
// Top level of the two-link planar arm solver: reach test, cosine, sine, three atan2s.
// Depends on tlik_pkg, tlik_div, tlik_sqrt, tlik_atan2 and the assertion header.
//
//  channel   signals                                   direction
//  command   start, busy, target_x, target_y           in (busy out)
//  result    strobe, status, solution_index,           out
//            shoulder_angle, elbow_angle, last
//  config    wr_en, wr_index, wr_data                  in
//
// A target cannot be taken back to back: busy is high for the cycle after each
// accepted beat, set by the two result beats a target may give on one channel.
// The first result beat is presented after the full pipeline depth, the alternate one in the
// cycle after it; the depth is set by the 30-stage divider, 31-stage root and 24-stage atan2.
// Reset clears valid bits, busy and the link lengths (1.0 each). Results cannot be held off.
`include "two_link_inverse_kinematics_defines.svh"
module two_link_inverse_kinematics import tlik_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [23:0] target_x,
	input  logic signed [23:0] target_y,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [21:0]        wr_data,
	output logic               strobe,
	output logic               status,
	output logic               solution_index,
	output logic [24:0]        shoulder_angle,
	output logic [24:0]        elbow_angle,
	output logic               last
);

	typedef struct packed {
		logic               over;
		logic               neg;
		logic               sat;
		logic               den0;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic [21:0]        l1;
		logic [21:0]        l2;
	} side_t;

	function automatic logic [24:0] to_deg(input logic [31:0] a);
		logic [40:0] w;
		logic [40:0] p;
		begin
			w = {9'b0, a};
			p = (w << 8) + (w << 6) + (w << 5) + (w << 3);
			return p[40:16];
		end
	endfunction

	logic [21:0] link1_q, link2_q;
	logic        busy_q;
	logic        acc;

	logic signed [47:0] xsq, ysq;
	logic [22:0]        lsum;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	side_t       side_s1, side_s2, side_s3, side_s4, side_s5, side_s9;
	side_t       side_n3, side_n4, side_n5;
	side_t       side_q [SIDE_LEN];
	logic [46:0] xx_s1, yy_s1;
	logic [45:0] rr_s1, rr_s2;
	logic [43:0] l11_s1, l22_s1, l12_s1, l12_s2;
	logic [47:0] d2_s2;
	logic [44:0] ll_s2;
	logic signed [49:0] num_s3;
	logic [44:0] den_s3, den_s4, den_s5;
	logic [48:0] an_s4;
	logic [44:0] r0_s5;

	logic        div_v;
	logic [29:0] div_q;
	side_t       side_c;
	logic signed [31:0] qs;
	logic signed [31:0] c_s6, c_s7, c_s8, c_s9, c_s10;
	logic signed [31:0] c_q [SQRT_STEPS];
	logic signed [63:0] csq;
	logic [60:0] cc_s7, rad_s8;
	logic        sq_v;
	logic [30:0] sq_r;

	logic [30:0]        s_s9, s_s10;
	logic [52:0]        l2s_s9;
	logic signed [53:0] l2c, l2c_s9;
	logic signed [54:0] vx_s10;
	logic [52:0]        vy_s10;
	logic signed [23:0] x_s10, y_s10;
	logic               over_s10;
	logic               ov_q [ATAN_LAT];

	logic        e_v, p_v, b_v;
	logic [31:0] e_ang, p_ang, b_ang;

	logic        v_s11, over_s11;
	logic [31:0] a1_s11, a1a_s11, e_s11, ea_s11;
	logic        v_s12, over_s12, alt_s12;
	logic [24:0] a1d_s12, a1ad_s12, ed_s12, ead_s12;

	logic        strobe_q, status_q, index_q, last_q, pend_q;
	logic [24:0] sh_q, el_q, sh_pend_q, el_pend_q;

	assign acc  = start && !busy_q;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link1_q <= 22'd4096;
			link2_q <= 22'd4096;
			busy_q  <= 1'b0;
		end else begin
			busy_q <= acc;
			if (wr_en && wr_index == REG_LINK1) link1_q <= wr_data;
			if (wr_en && wr_index == REG_LINK2) link2_q <= wr_data;
		end
	end

	assign xsq  = target_x * target_x;
	assign ysq  = target_y * target_y;
	assign lsum = {1'b0, link1_q} + {1'b0, link2_q};

	always_comb begin
		side_n3      = side_s2;
		side_n3.over = d2_s2 > {2'b0, rr_s2};
		side_n4      = side_s3;
		side_n4.neg  = num_s3[49];
		side_n5      = side_s4;
		side_n5.sat  = an_s4 >= {4'b0, den_s4};
		side_n5.den0 = den_s4 == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1    <= acc;
			side_s1 <= '{over: 1'b0, neg: 1'b0, sat: 1'b0, den0: 1'b0,
			             x: target_x, y: target_y, l1: link1_q, l2: link2_q};
			xx_s1   <= xsq[46:0];
			yy_s1   <= ysq[46:0];
			rr_s1   <= lsum * lsum;
			l11_s1  <= link1_q * link1_q;
			l22_s1  <= link2_q * link2_q;
			l12_s1  <= link1_q * link2_q;

			v_s2    <= v_s1;
			side_s2 <= side_s1;
			d2_s2   <= {1'b0, xx_s1} + {1'b0, yy_s1};
			ll_s2   <= {1'b0, l11_s1} + {1'b0, l22_s1};
			rr_s2   <= rr_s1;
			l12_s2  <= l12_s1;

			v_s3      <= v_s2;
			side_s3   <= side_n3;
			num_s3    <= $signed({2'b0, d2_s2}) - $signed({5'b0, ll_s2});
			den_s3    <= {l12_s2, 1'b0};

			v_s4      <= v_s3;
			side_s4   <= side_n4;
			an_s4     <= num_s3[49] ? 49'(-num_s3) : num_s3[48:0];
			den_s4    <= den_s3;

			v_s5      <= v_s4;
			side_s5   <= side_n5;
			r0_s5     <= an_s4[44:0];
			den_s5    <= den_s4;
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= side_s5;
		for (int i = 1; i < SIDE_LEN; i++) side_q[i] <= side_q[i-1];
	end

	tlik_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_rem    (r0_s5),
		.in_den    (den_s5),
		.out_valid (div_v),
		.out_quot  (div_q)
	);

	assign side_c = side_q[DIV_STEPS-1];
	assign qs     = $signed({2'b0, div_q});
	assign csq    = c_s6 * c_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s6 <= div_v;
			if (side_c.den0)     c_s6 <= ONE_Q30;
			else if (side_c.sat) c_s6 <= side_c.neg ? -ONE_Q30 : ONE_Q30;
			else                 c_s6 <= side_c.neg ? -qs : qs;
			v_s7   <= v_s6;
			c_s7   <= c_s6;
			cc_s7  <= csq[60:0];
			v_s8   <= v_s7;
			c_s8   <= c_s7;
			rad_s8 <= (61'(1) << 60) - cc_s7;
		end
	end

	always_ff @(posedge clk) begin
		c_q[0] <= c_s8;
		for (int i = 1; i < SQRT_STEPS; i++) c_q[i] <= c_q[i-1];
	end

	tlik_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s8),
		.in_rad    (rad_s8),
		.out_valid (sq_v),
		.out_root  (sq_r)
	);

	assign l2c = $signed({1'b0, side_q[SIDE_LEN-1].l2}) * c_q[SQRT_STEPS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			v_s9     <= sq_v;
			side_s9  <= side_q[SIDE_LEN-1];
			s_s9     <= sq_r;
			c_s9     <= c_q[SQRT_STEPS-1];
			l2s_s9   <= side_q[SIDE_LEN-1].l2 * sq_r;
			l2c_s9   <= l2c;
			v_s10    <= v_s9;
			vx_s10   <= $signed({3'b0, side_s9.l1, 30'b0}) + 55'(l2c_s9);
			vy_s10   <= l2s_s9;
			s_s10    <= s_s9;
			c_s10    <= c_s9;
			x_s10    <= side_s9.x;
			y_s10    <= side_s9.y;
			over_s10 <= side_s9.over;
		end
	end

	always_ff @(posedge clk) begin
		ov_q[0] <= over_s10;
		for (int i = 1; i < ATAN_LAT; i++) ov_q[i] <= ov_q[i-1];
	end

	tlik_atan2 u_elbow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s10),
		.in_y      ($signed({25'b0, s_s10})),
		.in_x      (ATAN_W'(c_s10)),
		.out_valid (e_v),
		.out_angle (e_ang)
	);

	tlik_atan2 u_phi (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s10),
		.in_y      ($signed({3'b0, vy_s10})),
		.in_x      (ATAN_W'(vx_s10)),
		.out_valid (p_v),
		.out_angle (p_ang)
	);

	tlik_atan2 u_base (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s10),
		.in_y      (ATAN_W'(y_s10)),
		.in_x      (ATAN_W'(x_s10)),
		.out_valid (b_v),
		.out_angle (b_ang)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			v_s11    <= e_v && p_v && b_v;
			over_s11 <= ov_q[ATAN_LAT-1];
			a1_s11   <= b_ang - p_ang;
			a1a_s11  <= b_ang + p_ang;
			e_s11    <= e_ang;
			ea_s11   <= 32'd0 - e_ang;
			v_s12    <= v_s11;
			over_s12 <= over_s11;
			alt_s12  <= ((a1_s11 - a1a_s11) > THRESH_BA) && ((a1a_s11 - a1_s11) > THRESH_BA)
			         && ((e_s11 - ea_s11) > THRESH_BA) && ((ea_s11 - e_s11) > THRESH_BA);
			a1d_s12  <= to_deg(a1_s11);
			a1ad_s12 <= to_deg(a1a_s11);
			ed_s12   <= to_deg(e_s11);
			ead_s12  <= to_deg(ea_s11);
		end
	end

	// second beat follows the first; commands are spaced so beats never collide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			pend_q   <= 1'b0;
		end else begin
			strobe_q <= pend_q || v_s12;
			pend_q   <= v_s12 && !over_s12 && alt_s12;
			if (pend_q) begin
				status_q <= ST_OK;
				index_q  <= SOL_ALT;
				sh_q     <= sh_pend_q;
				el_q     <= el_pend_q;
				last_q   <= 1'b1;
			end else begin
				status_q <= over_s12 ? ST_UNREACH : ST_OK;
				index_q  <= SOL_PRIMARY;
				sh_q     <= over_s12 ? '0 : a1d_s12;
				el_q     <= over_s12 ? '0 : ed_s12;
				last_q   <= over_s12 || !alt_s12;
			end
			sh_pend_q <= a1ad_s12;
			el_pend_q <= ead_s12;
		end
	end

	assign strobe         = strobe_q;
	assign status         = status_q;
	assign solution_index = index_q;
	assign shoulder_angle = sh_q;
	assign elbow_angle    = el_q;
	assign last           = last_q;

	`TLIK_ASSERT_NEXT(a_busy_after_beat, start && !busy, busy)
	`TLIK_ASSERT_NEXT(a_alt_follows, strobe && !last, strobe && solution_index)
	`TLIK_ASSERT(a_unreach_single, (strobe && status |-> last && !solution_index))

endmodule
